@@ sv/lbcc_pkg.sv @@
// D2Q9 BGK collision unit: shared types, constants, direction tables and helpers.
// Used by every module of the collision unit; depends on nothing else.
`timescale 1ns / 1ps
package lbcc_pkg;

	// Word format: signed Q4.28
	localparam int DW      = 32;
	localparam int FB      = 28;
	localparam int NDIR    = 9;
	localparam int SUM_W   = 36;  // exact sum of nine words
	localparam int MOM_W   = 35;  // exact momentum sum, six signed terms
	localparam int REM_W   = 64;  // divider remainder
	localparam int DIV_QB  = 33;  // quotient bits, top two bits flag overflow
	localparam int DIV_LAT = DIV_QB + 2;
	localparam int CFG_IDX_W = 4;
	localparam int INV_W   = 30;
	localparam int VIN_W   = 29;

	typedef logic signed [DW-1:0] word_t;

	localparam word_t FX_ONE = word_t'(64'd1 << FB);
	localparam word_t FX_MAX = word_t'((64'd1 << (DW - 1)) - 64'd1);
	localparam word_t FX_MIN = word_t'(64'd1 << (DW - 1));

	// Lattice weights rounded to nearest
	localparam word_t W_REST = word_t'((64'd8 * (64'd1 << FB) + 64'd9) / 64'd18);
	localparam word_t W_AXIS = word_t'((64'd2 * (64'd1 << FB) + 64'd9) / 64'd18);
	localparam word_t W_DIAG = word_t'((64'd2 * (64'd1 << FB) + 64'd36) / 64'd72);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_RELAX = 4'd0,
		REG_INLET_VEL = 4'd1
	} cfg_reg_t;

	// Direction tables
	localparam logic signed [1:0] DIR_CX [NDIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
		2'sd1, -2'sd1, -2'sd1, 2'sd1};
	localparam logic signed [1:0] DIR_CY [NDIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
		2'sd1, 2'sd1, -2'sd1, -2'sd1};
	localparam int DIR_BACK [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

	function automatic word_t dir_weight(input int d);
		word_t w;
		if (d == 0) w = W_REST;
		else if (d < 5) w = W_AXIS;
		else w = W_DIAG;
		return w;
	endfunction

	// Clamp to the signed word range
	function automatic word_t sat64(input logic signed [63:0] x);
		word_t r;
		if (x > 64'(FX_MAX)) r = FX_MAX;
		else if (x < 64'(FX_MIN)) r = FX_MIN;
		else r = word_t'(x);
		return r;
	endfunction

endpackage

@@ sv/lattice_boltzmann_cell_collision_unit.sv @@
// D2Q9 BGK cell collision top level: moment sums, two dividers, nine lanes, output merge.
// Depends on lbcc_pkg, lbcc_divider and lbcc_lane.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_ready   | dist_* (9 x 32b signed), is_solid, is_inlet
//   output   | out_valid / out_ready | post_* (9 x 32b signed), density, velocity_x/y
//   config   | cfg_valid / cfg_ready | cfg_index (4b), cfg_data (32b)
//
// One cell request per cycle while the output is not stalled; a cell passes the sums,
// divider, select, lanes and merge in that order; the divider yields one quotient bit per stage.
// The whole pipeline advances when the output register is empty or being taken,
// so a stall at the output holds every stage in place. Config writes take effect
// at once and are always ready. Reset clears valid bits and registers only.
`timescale 1ns / 1ps
module lattice_boltzmann_cell_collision_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lbcc_pkg::word_t       dist_rest,
	input  lbcc_pkg::word_t       dist_east,
	input  lbcc_pkg::word_t       dist_north,
	input  lbcc_pkg::word_t       dist_west,
	input  lbcc_pkg::word_t       dist_south,
	input  lbcc_pkg::word_t       dist_northeast,
	input  lbcc_pkg::word_t       dist_northwest,
	input  lbcc_pkg::word_t       dist_southwest,
	input  lbcc_pkg::word_t       dist_southeast,
	input  logic                  is_solid,
	input  logic                  is_inlet,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lbcc_pkg::word_t       post_rest,
	output lbcc_pkg::word_t       post_east,
	output lbcc_pkg::word_t       post_north,
	output lbcc_pkg::word_t       post_west,
	output lbcc_pkg::word_t       post_south,
	output lbcc_pkg::word_t       post_northeast,
	output lbcc_pkg::word_t       post_northwest,
	output lbcc_pkg::word_t       post_southwest,
	output lbcc_pkg::word_t       post_southeast,
	output lbcc_pkg::word_t       density,
	output lbcc_pkg::word_t       velocity_x,
	output lbcc_pkg::word_t       velocity_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [lbcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]           cfg_data
);
	import lbcc_pkg::*;

	typedef struct packed {
		logic  valid;
		logic  solid;
		logic  inlet;
		word_t rho;
		word_t [NDIR-1:0] f;
	} side_t;

	typedef struct packed {
		logic  valid;
		logic  solid;
		word_t rho;
		word_t ux;
		word_t uy;
	} mac_t;

	logic              en;
	logic [INV_W-1:0]  inv_q;
	logic [VIN_W-1:0]  vin_q;

	word_t             f_in [NDIR];
	side_t             in_s1;
	logic signed [SUM_W-1:0] sr_s1;
	logic signed [MOM_W-1:0] sx_s1, sy_s1;
	side_t             side_s [DIV_LAT];
	side_t             sd;
	word_t             qx, qy;

	word_t             rho_sel, ux_sel, uy_sel;
	logic              v_s3, solid_s3;
	word_t             rho_s3, ux_s3, uy_s3;
	word_t             f_s3 [NDIR];
	logic signed [63:0] sqx_s3, sqy_s3;
	word_t             uu_s4;
	mac_t              mac_s4, mac_s5, mac_s6, mac_s7;
	word_t             lane_post [NDIR];

	logic              out_valid_q, out_solid_q;
	word_t             post_q [NDIR];
	word_t             rho_q, ux_q, uy_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_W'(64'd1 << FB);
			vin_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_INV_RELAX) inv_q <= cfg_data[INV_W-1:0];
			else if (cfg_index == REG_INLET_VEL) vin_q <= cfg_data[VIN_W-1:0];
		end
	end

	// Stage 1: exact moment sums
	assign f_in = '{dist_rest, dist_east, dist_north, dist_west, dist_south,
		dist_northeast, dist_northwest, dist_southwest, dist_southeast};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1.valid <= 1'b0;
		end else if (en) begin
			in_s1.valid <= in_valid;
			in_s1.solid <= is_solid;
			in_s1.inlet <= is_inlet;
			in_s1.rho   <= '0;
			for (int d = 0; d < NDIR; d++) in_s1.f[d] <= f_in[d];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1 <= SUM_W'(f_in[0]) + SUM_W'(f_in[1]) + SUM_W'(f_in[2])
				+ SUM_W'(f_in[3]) + SUM_W'(f_in[4]) + SUM_W'(f_in[5])
				+ SUM_W'(f_in[6]) + SUM_W'(f_in[7]) + SUM_W'(f_in[8]);
			sx_s1 <= MOM_W'(f_in[1]) + MOM_W'(f_in[5]) + MOM_W'(f_in[8])
				- MOM_W'(f_in[3]) - MOM_W'(f_in[6]) - MOM_W'(f_in[7]);
			sy_s1 <= MOM_W'(f_in[2]) + MOM_W'(f_in[5]) + MOM_W'(f_in[6])
				- MOM_W'(f_in[4]) - MOM_W'(f_in[7]) - MOM_W'(f_in[8]);
		end
	end

	// Velocity dividers, one per axis
	word_t rho_s1;
	assign rho_s1 = sat64(64'(sr_s1));

	lbcc_divider u_div_x (.clk(clk), .en(en), .num(sx_s1), .den(rho_s1), .quo(qx));
	lbcc_divider u_div_y (.clk(clk), .en(en), .num(sy_s1), .den(rho_s1), .quo(qy));

	// Side line matching the divider latency
	for (genvar i = 0; i < DIV_LAT; i++) begin : g_side
		side_t nxt;
		if (i == 0) begin : g_head
			always_comb begin
				nxt     = in_s1;
				nxt.rho = rho_s1;
			end
		end else begin : g_body
			assign nxt = side_s[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i].valid <= 1'b0;
			end else if (en) begin
				side_s[i].valid <= nxt.valid;
				side_s[i].solid <= nxt.solid;
				side_s[i].inlet <= nxt.inlet;
				side_s[i].rho   <= nxt.rho;
				side_s[i].f     <= nxt.f;
			end
		end
	end

	assign sd = side_s[DIV_LAT-1];

	// Stage 3: macroscopic select for wall and inlet cells, velocity squares
	always_comb begin
		rho_sel = (sd.solid || sd.inlet) ? FX_ONE : sd.rho;
		ux_sel  = sd.solid ? '0 : (sd.inlet ? word_t'($signed(vin_q)) : qx);
		uy_sel  = (sd.solid || sd.inlet) ? '0 : qy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			solid_s3 <= sd.solid;
			rho_s3   <= rho_sel;
			ux_s3    <= ux_sel;
			uy_s3    <= uy_sel;
			sqx_s3   <= ux_sel * ux_sel;
			sqy_s3   <= uy_sel * uy_sel;
			for (int d = 0; d < NDIR; d++) f_s3[d] <= sd.f[d];
		end
	end

	// Stage 4: speed squared, shared by all lanes
	always_ff @(posedge clk) begin
		if (en) begin
			uu_s4 <= sat64(64'(sat64(sqx_s3 >>> FB)) + 64'(sat64(sqy_s3 >>> FB)));
		end
	end

	// Macroscopic values travel beside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s4.valid <= 1'b0;
			mac_s5.valid <= 1'b0;
			mac_s6.valid <= 1'b0;
			mac_s7.valid <= 1'b0;
		end else if (en) begin
			mac_s4.valid <= v_s3;
			mac_s4.solid <= solid_s3;
			mac_s4.rho   <= rho_s3;
			mac_s4.ux    <= ux_s3;
			mac_s4.uy    <= uy_s3;
			mac_s5 <= mac_s4;
			mac_s6 <= mac_s5;
			mac_s7 <= mac_s6;
		end
	end

	// Nine collision lanes
	for (genvar d = 0; d < NDIR; d++) begin : g_lane
		lbcc_lane u_lane (
			.clk    (clk),
			.en     (en),
			.cx     (DIR_CX[d]),
			.cy     (DIR_CY[d]),
			.weight (dir_weight(d)),
			.f      (f_s3[d]),
			.fback  (f_s3[DIR_BACK[d]]),
			.solid  (solid_s3),
			.rho    (rho_s3),
			.ux     (ux_s3),
			.uy     (uy_s3),
			.uu     (uu_s4),
			.inv    (inv_q),
			.post   (lane_post[d])
		);
	end

	// Merge: output register for the whole cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= mac_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_solid_q <= mac_s7.solid;
			rho_q       <= mac_s7.rho;
			ux_q        <= mac_s7.ux;
			uy_q        <= mac_s7.uy;
			for (int d = 0; d < NDIR; d++) post_q[d] <= lane_post[d];
		end
	end

	assign out_valid      = out_valid_q;
	assign post_rest      = post_q[0];
	assign post_east      = post_q[1];
	assign post_north     = post_q[2];
	assign post_west      = post_q[3];
	assign post_south     = post_q[4];
	assign post_northeast = post_q[5];
	assign post_northwest = post_q[6];
	assign post_southwest = post_q[7];
	assign post_southeast = post_q[8];
	assign density        = rho_q;
	assign velocity_x     = ux_q;
	assign velocity_y     = uy_q;

`ifndef SYNTH
	// Wall cells always report unit density at rest
	a_solid_macro: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_solid_q |-> rho_q == FX_ONE && ux_q == '0 && uy_q == '0)
		else $error("wall cell with nonzero macroscopic values");

	// Non-positive density never yields a velocity
	a_rho_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rho_s3 <= 0 |-> ux_s3 == '0 && uy_s3 == '0)
		else $error("velocity from non-positive density");

	// Output stall freezes the select stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(rho_s3) && $stable(ux_s3))
		else $error("pipeline moved during output stall");
`endif

endmodule

@@ sv/lbcc_divider.sv @@
// Pipelined restoring divider: saturated (num * 2^FB) / den, truncated toward zero.
// One quotient bit per stage; zero result for a non-positive divisor. Uses lbcc_pkg.
`timescale 1ns / 1ps
module lbcc_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [lbcc_pkg::MOM_W-1:0] num,
	input  lbcc_pkg::word_t             den,
	output lbcc_pkg::word_t             quo
);
	import lbcc_pkg::*;

	logic [REM_W-1:0]  rem_s  [DIV_QB+1];
	logic [DIV_QB-1:0] q_s    [DIV_QB+1];
	logic [DW-2:0]     den_s  [DIV_QB+1];
	logic              neg_s  [DIV_QB+1];
	logic              zero_s [DIV_QB+1];
	logic [MOM_W-1:0]  num_abs;
	logic              big;
	word_t             quo_q;

	// Setup: magnitude of the scaled numerator
	assign num_abs = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= REM_W'({num_abs, {FB{1'b0}}});
			q_s[0]    <= '0;
			den_s[0]  <= den[DW-2:0];
			neg_s[0]  <= num[MOM_W-1];
			zero_s[0] <= den[DW-1] || (den == '0);
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 1; j <= DIV_QB; j++) begin : g_step
		logic [REM_W-1:0] sh;
		logic             fit;
		assign sh  = REM_W'(den_s[j-1]) << (DIV_QB - j);
		assign fit = rem_s[j-1] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= fit ? rem_s[j-1] - sh : rem_s[j-1];
				q_s[j]    <= q_s[j-1] | (DIV_QB'(fit) << (DIV_QB - j));
				den_s[j]  <= den_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	// Sign and saturation
	assign big = q_s[DIV_QB][DIV_QB-1] | q_s[DIV_QB][DW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[DIV_QB]) quo_q <= '0;
			else if (big) quo_q <= neg_s[DIV_QB] ? FX_MIN : FX_MAX;
			else if (neg_s[DIV_QB]) quo_q <= -word_t'(q_s[DIV_QB][DW-1:0]);
			else quo_q <= word_t'(q_s[DIV_QB][DW-1:0]);
		end
	end

	assign quo = quo_q;

endmodule

@@ sv/lbcc_lane.sv @@
// One direction of the BGK relaxation: equilibrium, relaxation, bounce-back select.
// Four register stages; uu arrives in the cycle after the other inputs. Uses lbcc_pkg.
`timescale 1ns / 1ps
module lbcc_lane (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [1:0]      cx,
	input  logic signed [1:0]      cy,
	input  lbcc_pkg::word_t        weight,
	input  lbcc_pkg::word_t        f,
	input  lbcc_pkg::word_t        fback,
	input  logic                   solid,
	input  lbcc_pkg::word_t        rho,
	input  lbcc_pkg::word_t        ux,
	input  lbcc_pkg::word_t        uy,
	input  lbcc_pkg::word_t        uu,
	input  logic [lbcc_pkg::INV_W-1:0] inv,
	output lbcc_pkg::word_t        post
);
	import lbcc_pkg::*;

	logic signed [33:0] tx, ty, dot;
	logic signed [35:0] tri3;
	word_t              cu;

	word_t              cu_s1, f_s1, fb_s1;
	logic               solid_s1;
	logic signed [63:0] cu2_s1, wr_s1;

	word_t              cu2f, wrf, poly;
	logic signed [35:0] poly36;
	logic signed [63:0] prod_s2;
	word_t              f_s2, fb_s2;
	logic               solid_s2;

	word_t              feq, diff;
	logic signed [INV_W:0] inv_sg;
	logic signed [63:0] ip_s3;
	word_t              f_s3, fb_s3;
	logic               solid_s3;

	word_t              post_s4;

	// Stage 1: projected velocity, its square, weighted density
	always_comb begin
		tx   = (cx > 0) ? 34'(ux) : ((cx < 0) ? -34'(ux) : '0);
		ty   = (cy > 0) ? 34'(uy) : ((cy < 0) ? -34'(uy) : '0);
		dot  = tx + ty;
		tri3 = 36'(dot) + (36'(dot) <<< 1);
		cu   = sat64(64'(tri3));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s1    <= cu;
			cu2_s1   <= cu * cu;
			wr_s1    <= weight * rho;
			f_s1     <= f;
			fb_s1    <= fback;
			solid_s1 <= solid;
		end
	end

	// Stage 2: equilibrium polynomial times weighted density
	always_comb begin
		cu2f   = sat64(cu2_s1 >>> FB);
		wrf    = sat64(wr_s1 >>> FB);
		poly36 = 36'(FX_ONE) + 36'(cu_s1) + 36'(cu2f >>> 1) - (36'(uu) + 36'(uu >>> 1));
		poly   = sat64(64'(poly36));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2  <= wrf * poly;
			f_s2     <= f_s1;
			fb_s2    <= fb_s1;
			solid_s2 <= solid_s1;
		end
	end

	// Stage 3: deviation from equilibrium scaled by 1/tau
	always_comb begin
		feq    = sat64(prod_s2 >>> FB);
		diff   = sat64(64'(f_s2) - 64'(feq));
		inv_sg = $signed({1'b0, inv});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ip_s3    <= inv_sg * diff;
			f_s3     <= f_s2;
			fb_s3    <= fb_s2;
			solid_s3 <= solid_s2;
		end
	end

	// Stage 4: relaxed value, or the opposite direction for a wall
	always_ff @(posedge clk) begin
		if (en) begin
			post_s4 <= solid_s3 ? fb_s3 : sat64(64'(f_s3) - 64'(sat64(ip_s3 >>> FB)));
		end
	end

	assign post = post_s4;

endmodule

@@ dv/lattice_boltzmann_cell_collision_unit_tb.sv @@
// Self-checking testbench for the D2Q9 BGK cell collision unit: directed and random cells,
// a bit-accurate collision predictor, random stalls on both channels. Depends on lbcc_pkg.
`timescale 1ns / 1ps
module lattice_boltzmann_cell_collision_unit_tb;
	import lbcc_pkg::*;

	localparam int  NPHASE     = 6;
	localparam int  PHASE_N    = 300;
	localparam int  LIMIT      = 400000;
	localparam int  DRAIN_WAIT = 60;
	localparam int  HOLD_LEN   = 400;
	localparam longint ONE     = 64'sd1 <<< FB;
	localparam longint MONE    = -ONE;
	localparam longint WMAX    = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint WMIN    = -WMAX - 1;

	localparam int CX   [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int CY   [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
	localparam int BACK [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
	localparam int WNUM [NDIR] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
	localparam int WDEN [NDIR] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};

	typedef struct packed {
		logic [NDIR-1:0][DW-1:0] f;
		logic                    solid;
		logic                    inlet;
	} cell_t;

	typedef struct packed {
		logic [NDIR-1:0][DW-1:0] post;
		logic [DW-1:0]           rho;
		logic [DW-1:0]           ux;
		logic [DW-1:0]           uy;
	} moments_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	cell_t drv_cell;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	word_t o_post [NDIR];
	word_t o_rho, o_ux, o_uy;

	// Shadow copy of the registers
	longint relax_rate;
	longint inlet_ux;

	cell_t    pending_cells[$];
	moments_t expected_results[$];
	int  errors;
	int  cycles;
	int  send_idle_pct, recv_idle_pct;
	bit  hold_req;
	int  hold_left;

	lattice_boltzmann_cell_collision_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.dist_rest(drv_cell.f[0]), .dist_east(drv_cell.f[1]), .dist_north(drv_cell.f[2]),
		.dist_west(drv_cell.f[3]), .dist_south(drv_cell.f[4]),
		.dist_northeast(drv_cell.f[5]), .dist_northwest(drv_cell.f[6]),
		.dist_southwest(drv_cell.f[7]), .dist_southeast(drv_cell.f[8]),
		.is_solid(drv_cell.solid), .is_inlet(drv_cell.inlet),
		.out_valid(out_valid), .out_ready(out_ready),
		.post_rest(o_post[0]), .post_east(o_post[1]), .post_north(o_post[2]),
		.post_west(o_post[3]), .post_south(o_post[4]),
		.post_northeast(o_post[5]), .post_northwest(o_post[6]),
		.post_southwest(o_post[7]), .post_southeast(o_post[8]),
		.density(o_rho), .velocity_x(o_ux), .velocity_y(o_uy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_word(input longint x);
		if (x > WMAX) return WMAX;
		if (x < WMIN) return WMIN;
		return x;
	endfunction

	// Fixed-point product, rounded toward minus infinity
	function automatic longint fx_mul(input longint a, input longint b);
		return clamp_word((a * b) >>> FB);
	endfunction

	function automatic longint lattice_weight(input int d);
		return ((longint'(2 * WNUM[d]) <<< FB) + WDEN[d]) / (2 * WDEN[d]);
	endfunction

	// Expected collision result of one cell under the current registers
	function automatic moments_t collide_cell(input cell_t c);
		moments_t r;
		longint f [NDIR];
		longint rho, ux, uy, uu, sr, sx, sy, cu, cu2, poly, feq, diff, pv;
		for (int d = 0; d < NDIR; d++) f[d] = longint'($signed(c.f[d]));
		if (c.solid) begin
			for (int d = 0; d < NDIR; d++) r.post[d] = f[BACK[d]][DW-1:0];
			rho = ONE; ux = 0; uy = 0;
		end else begin
			if (c.inlet) begin
				rho = ONE; ux = inlet_ux; uy = 0;
			end else begin
				sr = 0; sx = 0; sy = 0;
				for (int d = 0; d < NDIR; d++) begin
					sr += f[d];
					sx += f[d] * CX[d];
					sy += f[d] * CY[d];
				end
				rho = clamp_word(sr);
				if (rho > 0) begin
					ux = clamp_word((sx * ONE) / rho);
					uy = clamp_word((sy * ONE) / rho);
				end else begin
					ux = 0; uy = 0;
				end
			end
			uu = clamp_word(fx_mul(ux, ux) + fx_mul(uy, uy));
			for (int d = 0; d < NDIR; d++) begin
				cu   = clamp_word(3 * (CX[d] * ux + CY[d] * uy));
				cu2  = fx_mul(cu, cu);
				poly = clamp_word(ONE + cu + (cu2 >>> 1) - (uu + (uu >>> 1)));
				feq  = fx_mul(fx_mul(lattice_weight(d), rho), poly);
				diff = clamp_word(f[d] - feq);
				pv   = clamp_word(f[d] - fx_mul(relax_rate, diff));
				r.post[d] = pv[DW-1:0];
			end
		end
		r.rho = rho[DW-1:0];
		r.ux  = ux[DW-1:0];
		r.uy  = uy[DW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Input driver: takes the next cell when the current request is gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_cell <= '0;
		end else begin
			if (in_valid && in_ready) expected_results.push_back(collide_cell(drv_cell));
			if (!in_valid || in_ready) begin
				if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					drv_cell <= pending_cells.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result and throttles out_ready
	always @(posedge clk or negedge arst_n) begin
		moments_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("UNEXPECTED result at cycle %0d", cycles);
					errors++;
				end else begin
					want = expected_results.pop_front();
					for (int d = 0; d < NDIR; d++)
						if (o_post[d] !== want.post[d])
							report_mismatch($sformatf("post[%0d]", d), o_post[d], want.post[d]);
					if (o_rho !== want.rho) report_mismatch("density", o_rho, want.rho);
					if (o_ux !== want.ux) report_mismatch("velocity_x", o_ux, want.ux);
					if (o_uy !== want.uy) report_mismatch("velocity_y", o_uy, want.uy);
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_INV_RELAX) relax_rate = longint'(value[INV_W-1:0]);
		else inlet_ux = longint'($signed(value[VIN_W-1:0]));
	endtask

	task automatic wait_drained();
		while (pending_cells.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DW-1:0] pick_extreme();
		case ($urandom_range(5))
			0: return WMAX[DW-1:0];
			1: return WMIN[DW-1:0];
			2: return '0;
			3: return ONE[DW-1:0];
			4: return MONE[DW-1:0];
			default: return $urandom;
		endcase
	endfunction

	// Random cell: mostly near equilibrium, some raw noise, tiny and extreme values
	function automatic cell_t make_cell();
		cell_t c;
		int kind;
		longint rho0, v;
		kind = $urandom_range(9);
		rho0 = ONE + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
		for (int d = 0; d < NDIR; d++) begin
			if (kind < 6) begin
				v = ((lattice_weight(d) * rho0) >>> FB) + $signed($urandom_range(0, 1 << 25))
					- (1 << 24);
				c.f[d] = v[DW-1:0];
			end else if (kind < 8) begin
				c.f[d] = $urandom;
			end else if (kind == 8) begin
				v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
				c.f[d] = v[DW-1:0];
			end else begin
				c.f[d] = pick_extreme();
			end
		end
		c.solid = ($urandom_range(99) < 15);
		c.inlet = ($urandom_range(99) < 15);
		return c;
	endfunction

	task automatic push_uniform(input logic [DW-1:0] v, input bit s, input bit i);
		cell_t c;
		for (int d = 0; d < NDIR; d++) c.f[d] = v;
		c.solid = s;
		c.inlet = i;
		pending_cells.push_back(c);
	endtask

	// Directed cells under the reset register values
	task automatic push_directed();
		cell_t c;
		longint v;
		push_uniform('0, 0, 0);
		push_uniform(WMAX[DW-1:0], 0, 0);
		push_uniform(WMIN[DW-1:0], 0, 0);
		push_uniform(MONE[DW-1:0], 0, 0);
		push_uniform(WMAX[DW-1:0], 1, 0);
		push_uniform(WMIN[DW-1:0], 0, 1);
		// rest equilibrium at unit density
		for (int d = 0; d < NDIR; d++) begin
			v = lattice_weight(d);
			c.f[d] = v[DW-1:0];
		end
		c.solid = 0; c.inlet = 0;
		pending_cells.push_back(c);
		c.inlet = 1;
		pending_cells.push_back(c);
		// bounce-back with distinct values, alone and with the inlet flag
		for (int d = 0; d < NDIR; d++) c.f[d] = 32'h1000_0000 + d * 32'h0111_1111;
		c.solid = 1; c.inlet = 0;
		pending_cells.push_back(c);
		c.inlet = 1;
		pending_cells.push_back(c);
		// density near two with strong east flow: the projected velocity saturates in the lanes
		c = '0;
		c.f[0] = 1; c.f[1] = 32'h4000_0000;
		c.f[3] = 32'hC000_0001;
		c.f[2] = 32'h2000_0000;
		pending_cells.push_back(c);
		// zero density with momentum
		c = '0;
		c.f[1] = ONE[DW-1:0]; c.f[3] = MONE[DW-1:0];
		c.f[5] = ONE[DW-1:0]; c.f[7] = MONE[DW-1:0];
		c.f[2] = ONE[DW-1:0]; c.f[4] = MONE[DW-1:0];
		pending_cells.push_back(c);
		// negative density
		c = '0;
		for (int d = 0; d < NDIR; d++) begin
			v = -(ONE >>> 3) + d;
			c.f[d] = v[DW-1:0];
		end
		v = ONE >>> 2;
		c.f[8] = v[DW-1:0];
		pending_cells.push_back(c);
		// alternating extremes in every direction
		for (int d = 0; d < NDIR; d++) c.f[d] = (d % 2) ? WMAX[DW-1:0] : WMIN[DW-1:0];
		c.solid = 0; c.inlet = 0;
		pending_cells.push_back(c);
		for (int d = 0; d < NDIR; d++) c.f[d] = (d % 2) ? WMIN[DW-1:0] : WMAX[DW-1:0];
		pending_cells.push_back(c);
		for (int k = 0; k < 5; k++) pending_cells.push_back(make_cell());
	endtask

	// Stimulus sequencing
	initial begin
		logic [31:0] inv_v, vin_v;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		hold_req = 1'b0;
		relax_rate = ONE;
		inlet_ux = 0;
		send_idle_pct = 16;
		recv_idle_pct = 84;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_directed();
		wait_drained();

		for (int p = 0; p < NPHASE; p++) begin
			case (p)
				0: begin inv_v = 32'h1000_0000; vin_v = 32'h0400_0000; end
				1: begin inv_v = 32'h0;         vin_v = 32'hF800_0000; end
				2: begin inv_v = 32'h2000_0000; vin_v = 32'h0800_0000; end
				3: begin
					inv_v = $urandom_range(0, 32'h2000_0000);
					vin_v = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
				end
				4: begin inv_v = $urandom; vin_v = $urandom; end
				default: begin
					inv_v = $urandom_range(32'h1300_0000, 32'h1E00_0000);
					vin_v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
				end
			endcase
			write_reg(REG_INV_RELAX, inv_v);
			write_reg(REG_INLET_VEL, vin_v);
			if (p < 2) begin
				send_idle_pct = 16; recv_idle_pct = 84;
			end else if (p < 4) begin
				send_idle_pct = 84; recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			for (int k = 0; k < PHASE_N; k++) pending_cells.push_back(make_cell());
			// long output stall while the sender keeps pushing
			if (p == 4) hold_req = 1'b1;
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/lbcc_pkg.sv
sv/lbcc_divider.sv
sv/lbcc_lane.sv
sv/lattice_boltzmann_cell_collision_unit.sv
dv/lattice_boltzmann_cell_collision_unit_tb.sv
